>>> design/aec_pkg.sv
`default_nettype none

package aec_pkg;

   // operation codes of the request channel
   localparam logic [1:0] OP_DETECT = 2'd0;
   localparam logic [1:0] OP_TICK   = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   // alert level codes
   localparam logic [2:0] LVL_NONE     = 3'd0;
   localparam logic [2:0] LVL_LOW      = 3'd1;
   localparam logic [2:0] LVL_MEDIUM   = 3'd2;
   localparam logic [2:0] LVL_HIGH     = 3'd3;
   localparam logic [2:0] LVL_CRITICAL = 3'd4;

   // configuration register indexes
   localparam int CSR_IDX_W = 8;
   localparam logic [CSR_IDX_W-1:0] REG_MEDIUM_AFTER  = 8'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_AFTER    = 8'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CRIT_AFTER    = 8'd2;
   localparam logic [CSR_IDX_W-1:0] REG_LOW_DUR       = 8'd3;
   localparam logic [CSR_IDX_W-1:0] REG_MEDIUM_DUR    = 8'd4;
   localparam logic [CSR_IDX_W-1:0] REG_HIGH_DUR      = 8'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CRIT_DUR      = 8'd6;
   localparam logic [CSR_IDX_W-1:0] REG_COOLDOWN      = 8'd7;

   // configuration reset values
   localparam logic [31:0] RST_MEDIUM_AFTER = 32'd3000;
   localparam logic [31:0] RST_HIGH_AFTER   = 32'd3000;
   localparam logic [31:0] RST_CRIT_AFTER   = 32'd3000;
   localparam logic [31:0] RST_LOW_DUR      = 32'd5000;
   localparam logic [31:0] RST_MEDIUM_DUR   = 32'd8000;
   localparam logic [31:0] RST_HIGH_DUR     = 32'd12000;
   localparam logic [31:0] RST_CRIT_DUR     = 32'd20000;
   localparam logic [31:0] RST_COOLDOWN     = 32'd2000;

   // buzzer tones and pattern timing
   localparam logic [11:0] TONE_NOD_HZ   = 12'd1000;
   localparam logic [11:0] TONE_EYES_HZ  = 12'd800;
   localparam logic [11:0] TONE_HIGH_HZ  = 12'd2500;
   localparam logic [11:0] TONE_MID_HZ   = 12'd2000;
   localparam int          PAT_STEP_MS   = 200;
   localparam int          PAT_MID_FIRST = 4;
   localparam int          PAT_MID_LAST  = 6;

   typedef struct packed {
      logic [31:0] medium_after_ms;
      logic [31:0] high_after_ms;
      logic [31:0] critical_after_ms;
      logic [31:0] low_duration_ms;
      logic [31:0] medium_duration_ms;
      logic [31:0] high_duration_ms;
      logic [31:0] critical_duration_ms;
      logic [31:0] cooldown_ms;
   } cfg_type;

   // alert state that does not depend on the time width
   typedef struct packed {
      logic        active;
      logic [2:0]  level;
      logic        cooling;
      logic        buzzer_on;
      logic [11:0] buzzer_freq;
      logic [7:0]  duty;
      logic [8:0]  blink;
   } ctrl_type;

   typedef struct packed {
      logic        alert_on;
      logic [2:0]  alert_level;
      logic        in_cooldown;
      logic [7:0]  flash_duty;
      logic [8:0]  blink_interval_ms;
      logic        tone_on;
      logic [11:0] tone_hz;
   } rsp_type;

   // flash duty per level, unknown codes look like low
   function automatic logic [7:0] duty_of(input logic [2:0] lvl);
      logic [7:0] d;
      case (lvl)
         LVL_MEDIUM:   d = 8'd125;
         LVL_HIGH:     d = 8'd200;
         LVL_CRITICAL: d = 8'd255;
         default:      d = 8'd50;
      endcase
      return d;
   endfunction

   // blink period per level, unknown codes look like low
   function automatic logic [8:0] blink_of(input logic [2:0] lvl);
      logic [8:0] b;
      case (lvl)
         LVL_MEDIUM:   b = 9'd300;
         LVL_HIGH:     b = 9'd150;
         LVL_CRITICAL: b = 9'd80;
         default:      b = 9'd500;
      endcase
      return b;
   endfunction

endpackage

`default_nettype wire

>>> design/aec_csr.sv
`default_nettype none

module aec_csr
   import aec_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data,
   output      cfg_type              cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // decode the written register, indexes past the list are dropped
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_MEDIUM_AFTER: cfg_in.medium_after_ms      = csr_data;
            REG_HIGH_AFTER:   cfg_in.high_after_ms        = csr_data;
            REG_CRIT_AFTER:   cfg_in.critical_after_ms    = csr_data;
            REG_LOW_DUR:      cfg_in.low_duration_ms      = csr_data;
            REG_MEDIUM_DUR:   cfg_in.medium_duration_ms   = csr_data;
            REG_HIGH_DUR:     cfg_in.high_duration_ms     = csr_data;
            REG_CRIT_DUR:     cfg_in.critical_duration_ms = csr_data;
            REG_COOLDOWN:     cfg_in.cooldown_ms          = csr_data;
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.medium_after_ms      <= RST_MEDIUM_AFTER;
         cfg_ff.high_after_ms        <= RST_HIGH_AFTER;
         cfg_ff.critical_after_ms    <= RST_CRIT_AFTER;
         cfg_ff.low_duration_ms      <= RST_LOW_DUR;
         cfg_ff.medium_duration_ms   <= RST_MEDIUM_DUR;
         cfg_ff.high_duration_ms     <= RST_HIGH_DUR;
         cfg_ff.critical_duration_ms <= RST_CRIT_DUR;
         cfg_ff.cooldown_ms          <= RST_COOLDOWN;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

`default_nettype wire

>>> design/aec_update.sv
`default_nettype none

module aec_update
   import aec_pkg::*;
#(
   parameter int TIME_BITS = 32,
   parameter int STEP_W    = 4,
   parameter int PATTERN_STEPS = 9
) (
   input  wire logic [1:0]           op,
   input  wire logic                 nod,
   input  wire logic [TIME_BITS-1:0] now_t,
   input  wire cfg_type              cfg,
   input  wire ctrl_type             ctrl,
   input  wire logic [TIME_BITS-1:0] last_t,
   input  wire logic [TIME_BITS-1:0] start_t,
   input  wire logic [TIME_BITS-1:0] level_t,
   input  wire logic [TIME_BITS-1:0] pat_t,
   input  wire logic [STEP_W-1:0]    step,
   output      ctrl_type             ctrl_nx,
   output      logic [TIME_BITS-1:0] last_nx,
   output      logic [TIME_BITS-1:0] start_nx,
   output      logic [TIME_BITS-1:0] level_nx,
   output      logic [TIME_BITS-1:0] pat_nx,
   output      logic [STEP_W-1:0]    step_nx,
   output      rsp_type              rsp
);

   localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

   logic [CMP_W-1:0]  cool_dt;
   logic [CMP_W-1:0]  lvl_dt;
   logic [CMP_W-1:0]  start_dt;
   logic [CMP_W-1:0]  pat_dt;
   logic [31:0]       dur;
   logic              cool_block;
   logic              expired;
   logic              end_now;
   logic [STEP_W:0]   step_inc;
   logic [STEP_W-1:0] step_wrap;
   logic              mid_tone;

   // elapsed times modulo the time width
   assign cool_dt  = CMP_W'(TIME_BITS'(now_t - last_t));
   assign lvl_dt   = CMP_W'(TIME_BITS'(now_t - level_t));
   assign start_dt = CMP_W'(TIME_BITS'(now_t - start_t));
   assign pat_dt   = CMP_W'(TIME_BITS'(now_t - pat_t));

   // lifetime of the alert at the current level
   always_comb begin
      case (ctrl.level)
         LVL_LOW:      dur = cfg.low_duration_ms;
         LVL_MEDIUM:   dur = cfg.medium_duration_ms;
         LVL_HIGH:     dur = cfg.high_duration_ms;
         LVL_CRITICAL: dur = cfg.critical_duration_ms;
         default:      dur = 32'd0;
      endcase
   end

   assign cool_block = ctrl.cooling && (cool_dt < CMP_W'(cfg.cooldown_ms));
   assign expired    = start_dt > CMP_W'(dur);
   assign end_now    = ctrl.active &&
                       ((op == OP_CLEAR) || ((op == OP_TICK) && expired));

   // next buzzer pattern step, wrapping back to the first step
   assign step_inc  = {1'b0, step} + (STEP_W+1)'(1);
   assign step_wrap = (step_inc > (STEP_W+1)'(PATTERN_STEPS)) ? STEP_W'(1)
                                                              : step_inc[STEP_W-1:0];
   assign mid_tone  = (step_wrap >= STEP_W'(PAT_MID_FIRST)) &&
                      (step_wrap <= STEP_W'(PAT_MID_LAST));

   // state update for one item
   always_comb begin
      ctrl_nx  = ctrl;
      last_nx  = last_t;
      start_nx = start_t;
      level_nx = level_t;
      pat_nx   = pat_t;
      step_nx  = step;
      case (op)
         OP_DETECT: begin
            if (!cool_block) begin
               ctrl_nx.cooling = 1'b0;
               if (ctrl.active) begin
                  // escalate by at most one level
                  if (ctrl.level == LVL_LOW &&
                      lvl_dt > CMP_W'(cfg.medium_after_ms)) begin
                     ctrl_nx.level = LVL_MEDIUM;
                     level_nx      = now_t;
                  end else if (ctrl.level == LVL_MEDIUM &&
                               lvl_dt > CMP_W'(cfg.high_after_ms)) begin
                     ctrl_nx.level = LVL_HIGH;
                     level_nx      = now_t;
                  end else if (ctrl.level == LVL_HIGH &&
                               lvl_dt > CMP_W'(cfg.critical_after_ms)) begin
                     ctrl_nx.level = LVL_CRITICAL;
                     level_nx      = now_t;
                  end
                  ctrl_nx.duty  = duty_of(ctrl_nx.level);
                  ctrl_nx.blink = blink_of(ctrl_nx.level);
               end else begin
                  // start a new alert at low level
                  ctrl_nx.level       = LVL_LOW;
                  ctrl_nx.duty        = duty_of(LVL_LOW);
                  ctrl_nx.blink       = blink_of(LVL_LOW);
                  ctrl_nx.buzzer_freq = nod ? TONE_NOD_HZ : TONE_EYES_HZ;
                  ctrl_nx.buzzer_on   = 1'b1;
                  ctrl_nx.active      = 1'b1;
                  level_nx            = now_t;
                  start_nx            = now_t;
                  last_nx             = now_t;
               end
            end
         end
         OP_TICK: begin
            // buzzer pattern at critical level while the alert lives
            if (ctrl.active && !expired && ctrl.level == LVL_CRITICAL) begin
               if (step == '0) begin
                  step_nx             = STEP_W'(1);
                  pat_nx              = now_t;
                  ctrl_nx.buzzer_freq = TONE_HIGH_HZ;
                  ctrl_nx.buzzer_on   = 1'b1;
               end else if (pat_dt > CMP_W'(PAT_STEP_MS)) begin
                  pat_nx  = now_t;
                  step_nx = step_wrap;
                  if (ctrl.buzzer_on) begin
                     ctrl_nx.buzzer_on = 1'b0;
                  end else begin
                     ctrl_nx.buzzer_freq = mid_tone ? TONE_MID_HZ : TONE_HIGH_HZ;
                     ctrl_nx.buzzer_on   = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      // ending the alert, blink period keeps its value
      if (end_now) begin
         ctrl_nx.duty      = '0;
         ctrl_nx.buzzer_on = 1'b0;
         ctrl_nx.active    = 1'b0;
         ctrl_nx.level     = LVL_NONE;
         ctrl_nx.cooling   = 1'b1;
         step_nx           = '0;
         last_nx           = now_t;
      end
   end

   // result fields from the updated state
   always_comb begin
      rsp.alert_on          = ctrl_nx.active;
      rsp.alert_level       = ctrl_nx.level;
      rsp.in_cooldown       = ctrl_nx.cooling;
      rsp.flash_duty        = ctrl_nx.duty;
      rsp.blink_interval_ms = ctrl_nx.blink;
      rsp.tone_on           = ctrl_nx.buzzer_on;
      rsp.tone_hz           = ctrl_nx.buzzer_on ? ctrl_nx.buzzer_freq : '0;
   end

endmodule

`default_nettype wire

>>> design/alert_escalation_controller.sv
`default_nettype none

// channel | direction | handshake            | payload
// req     | in        | req_valid, req_stall | operation, nodding, now_ms
// rsp     | out       | rsp_valid, rsp_stall | alert, level, cooldown, flash, blink, tone
// csr     | in        | csr_valid, csr_ready | csr_index, csr_data
//
// one request per cycle while req_stall is low; a request goes into the request register, its
// result into the result register, which holds it while rsp_stall is high
// reset clears all alert state and loads the register defaults; no clearing pass
// a stalled result holds the request register, which then stalls req
// registers are always ready and take effect for the next request processed

module alert_escalation_controller
   import aec_pkg::*;
#(
   parameter int PATTERN_STEPS = 9,
   parameter int TIME_BITS     = 32
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic [1:0]           req_operation,
   input  wire logic                 req_nodding,
   input  wire logic [31:0]          req_now_ms,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic                 rsp_alert_on,
   output      logic [2:0]           rsp_alert_level,
   output      logic                 rsp_in_cooldown,
   output      logic [7:0]           rsp_flash_duty,
   output      logic [8:0]           rsp_blink_interval_ms,
   output      logic                 rsp_tone_on,
   output      logic [11:0]          rsp_tone_hz,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [31:0]          csr_data
);

   localparam int STEP_W = $clog2(PATTERN_STEPS + 1);
   localparam int WIDE_W = (TIME_BITS > 32) ? TIME_BITS : 32;

   cfg_type              cfg;

   logic                 in_valid_ff;
   logic [1:0]           in_op_ff;
   logic                 in_nod_ff;
   logic [TIME_BITS-1:0] in_now_ff;
   logic [WIDE_W-1:0]    now_wide;

   ctrl_type             ctrl_ff;
   ctrl_type             ctrl_in;
   logic [TIME_BITS-1:0] last_ff, last_in;
   logic [TIME_BITS-1:0] start_ff, start_in;
   logic [TIME_BITS-1:0] level_t_ff, level_t_in;
   logic [TIME_BITS-1:0] pat_t_ff, pat_t_in;
   logic [STEP_W-1:0]    step_ff, step_in;

   logic                 rsp_valid_ff;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;

   logic                 advance;
   logic                 req_take;

   aec_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // handshake between the two stages
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;
   assign now_wide  = WIDE_W'(req_now_ms);

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
      if (req_take) begin
         in_op_ff  <= req_operation;
         in_nod_ff <= req_nodding;
         in_now_ff <= now_wide[TIME_BITS-1:0];
      end
   end

   aec_update #(
      .TIME_BITS     (TIME_BITS),
      .STEP_W        (STEP_W),
      .PATTERN_STEPS (PATTERN_STEPS)
   ) u_update (
      .op       (in_op_ff),
      .nod      (in_nod_ff),
      .now_t    (in_now_ff),
      .cfg      (cfg),
      .ctrl     (ctrl_ff),
      .last_t   (last_ff),
      .start_t  (start_ff),
      .level_t  (level_t_ff),
      .pat_t    (pat_t_ff),
      .step     (step_ff),
      .ctrl_nx  (ctrl_in),
      .last_nx  (last_in),
      .start_nx (start_in),
      .level_nx (level_t_in),
      .pat_nx   (pat_t_in),
      .step_nx  (step_in),
      .rsp      (rsp_in)
   );

   // alert state, updated as each request moves to the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff    <= '0;
         last_ff    <= '0;
         start_ff   <= '0;
         level_t_ff <= '0;
         pat_t_ff   <= '0;
         step_ff    <= '0;
      end else if (advance) begin
         ctrl_ff    <= ctrl_in;
         last_ff    <= last_in;
         start_ff   <= start_in;
         level_t_ff <= level_t_in;
         pat_t_ff   <= pat_t_in;
         step_ff    <= step_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_alert_on          = rsp_ff.alert_on;
   assign rsp_alert_level       = rsp_ff.alert_level;
   assign rsp_in_cooldown       = rsp_ff.in_cooldown;
   assign rsp_flash_duty        = rsp_ff.flash_duty;
   assign rsp_blink_interval_ms = rsp_ff.blink_interval_ms;
   assign rsp_tone_on           = rsp_ff.tone_on;
   assign rsp_tone_hz           = rsp_ff.tone_hz;

   // an active alert always has a level and an idle one never does
   a_level_matches_active: assert property (@(posedge clock) disable iff (reset)
      ctrl_ff.active == (ctrl_ff.level != LVL_NONE))
      else $error("alert active flag and level disagree");

   // the buzzer pattern runs only at critical level and stays in range
   a_pattern_step: assert property (@(posedge clock) disable iff (reset)
      (step_ff <= STEP_W'(PATTERN_STEPS)) &&
      ((step_ff == '0) || (ctrl_ff.level == LVL_CRITICAL)))
      else $error("buzzer pattern step out of place");

   // no alert means dark flash, silent buzzer and no level
   a_idle_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_alert_on |->
         (rsp_alert_level == LVL_NONE) && (rsp_flash_duty == '0) && !rsp_tone_on)
      else $error("idle result shows alert outputs");

   // a held result with a full request register must stall requests
   a_backpressure: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall && in_valid_ff |-> req_stall ##1 $stable(rsp_alert_level))
      else $error("request stage overran a held result");

endmodule

`default_nettype wire
